/* rtl/bpiou_pkg.sv */
package bpiou_pkg;

    localparam int COORD_BITS      = 16;
    localparam int RATIO_FRAC_BITS = 16;

    localparam int EPS_W   = 16;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int INTER_W = 2 * COORD_BITS;
    localparam int AREA_W  = 2 * DIFF_W;
    localparam int UNI_W   = AREA_W + 2;
    localparam int DEN_W   = UNI_W - 1;
    localparam int RATIO_W = RATIO_FRAC_BITS + 1;

    localparam int IN_DATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RATIO_W + 7) / 8) * 8;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // last field (a_left) in the lowest bits
    typedef struct packed {
        coord_t b_bottom;
        coord_t b_right;
        coord_t b_top;
        coord_t b_left;
        coord_t a_bottom;
        coord_t a_right;
        coord_t a_top;
        coord_t a_left;
    } box_pair_t;

    // request handed from the geometry stages to the divider
    typedef struct packed {
        logic             degen;
        logic             sat;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

/* rtl/bpiou_geom.sv */
module bpiou_geom
    import bpiou_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  box_pair_t        in_box,
    input  logic [EPS_W-1:0] epsilon,
    output logic             out_valid,
    output div_req_t         out_req
);

    logic [3:0] valid_reg;
    logic [3:0] valid_next;

    // stage 1: overlap extents and box sides
    logic        [COORD_BITS-1:0] iw_reg, ih_reg, iw_next, ih_next;
    logic signed [DIFF_W-1:0]     wa_reg, ha_reg, wb_reg, hb_reg;
    logic signed [DIFF_W-1:0]     wa_next, ha_next, wb_next, hb_next;
    // stage 2: areas
    logic        [INTER_W-1:0]    inter2_reg, inter2_next;
    logic signed [AREA_W-1:0]     area_a_reg, area_b_reg, area_a_next, area_b_next;
    // stage 3: union
    logic        [INTER_W-1:0]    inter3_reg;
    logic signed [UNI_W-1:0]      uni_reg, uni_next;
    // stage 4: flags
    div_req_t                     req_reg, req_next;

    coord_t                   x_lo, x_hi, y_lo, y_hi;
    logic signed [DIFF_W-1:0] ow, oh;

    always_comb
    begin
        x_lo = (in_box.a_right  < in_box.b_right)  ? in_box.a_right  : in_box.b_right;
        x_hi = (in_box.a_left   > in_box.b_left)   ? in_box.a_left   : in_box.b_left;
        y_lo = (in_box.a_bottom < in_box.b_bottom) ? in_box.a_bottom : in_box.b_bottom;
        y_hi = (in_box.a_top    > in_box.b_top)    ? in_box.a_top    : in_box.b_top;
        ow   = DIFF_W'(x_lo) - DIFF_W'(x_hi);
        oh   = DIFF_W'(y_lo) - DIFF_W'(y_hi);
        iw_next = ow[DIFF_W-1] ? '0 : ow[COORD_BITS-1:0];
        ih_next = oh[DIFF_W-1] ? '0 : oh[COORD_BITS-1:0];
        wa_next = DIFF_W'(in_box.a_right)  - DIFF_W'(in_box.a_left);
        ha_next = DIFF_W'(in_box.a_bottom) - DIFF_W'(in_box.a_top);
        wb_next = DIFF_W'(in_box.b_right)  - DIFF_W'(in_box.b_left);
        hb_next = DIFF_W'(in_box.b_bottom) - DIFF_W'(in_box.b_top);

        inter2_next = iw_reg * ih_reg;
        area_a_next = wa_reg * ha_reg;
        area_b_next = wb_reg * hb_reg;

        uni_next = UNI_W'(area_a_reg) + UNI_W'(area_b_reg)
                 - UNI_W'($signed({1'b0, inter2_reg}))
                 + UNI_W'($signed({1'b0, epsilon}));

        // union not positive: sign bit set or all zero
        req_next.degen = uni_reg[UNI_W-1] || (uni_reg == '0);
        req_next.num   = DEN_W'(inter3_reg);
        req_next.den   = uni_reg[DEN_W-1:0];
        req_next.sat   = (DEN_W'(inter3_reg) >= uni_reg[DEN_W-1:0]);

        valid_next = {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iw_reg     <= iw_next;
            ih_reg     <= ih_next;
            wa_reg     <= wa_next;
            ha_reg     <= ha_next;
            wb_reg     <= wb_next;
            hb_reg     <= hb_next;
            inter2_reg <= inter2_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
            inter3_reg <= inter2_reg;
            uni_reg    <= uni_next;
            req_reg    <= req_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_req   = req_reg;

endmodule

/* rtl/bpiou_div.sv */
module bpiou_div
    import bpiou_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  div_req_t           in_req,
    output logic               out_valid,
    output logic [RATIO_W-1:0] out_ratio,
    output logic               out_degen
);

    localparam int STAGES = RATIO_FRAC_BITS;

    // one quotient bit per stage
    logic [STAGES-1:0]          v_reg, v_next;
    logic [DEN_W-1:0]           r_reg   [STAGES];
    logic [DEN_W-1:0]           r_next  [STAGES];
    logic [DEN_W-1:0]           d_reg   [STAGES];
    logic [DEN_W-1:0]           d_next  [STAGES];
    logic [STAGES-1:0]          q_reg   [STAGES];
    logic [STAGES-1:0]          q_next  [STAGES];
    logic [STAGES-1:0]          sat_reg, sat_next, dg_reg, dg_next;

    logic                       ov_reg, ov_next;
    logic [RATIO_W-1:0]         ratio_reg, ratio_next;
    logic                       degen_reg, degen_next;

    logic [DEN_W-1:0]           r_src   [STAGES];
    logic [DEN_W-1:0]           d_src   [STAGES];
    logic [STAGES-1:0]          q_src   [STAGES];
    logic [DEN_W:0]             r_dbl   [STAGES];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                r_src[k]    = in_req.num;
                d_src[k]    = in_req.den;
                q_src[k]    = '0;
                v_next[k]   = in_valid;
                sat_next[k] = in_req.sat;
                dg_next[k]  = in_req.degen;
            end
            else
            begin
                r_src[k]    = r_reg[k-1];
                d_src[k]    = d_reg[k-1];
                q_src[k]    = q_reg[k-1];
                v_next[k]   = v_reg[k-1];
                sat_next[k] = sat_reg[k-1];
                dg_next[k]  = dg_reg[k-1];
            end
            r_dbl[k]  = {r_src[k], 1'b0};
            d_next[k] = d_src[k];
            if (r_dbl[k] >= {1'b0, d_src[k]})
            begin
                r_next[k] = DEN_W'(r_dbl[k] - {1'b0, d_src[k]});
                q_next[k] = {q_src[k][STAGES-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = r_dbl[k][DEN_W-1:0];
                q_next[k] = {q_src[k][STAGES-2:0], 1'b0};
            end
        end

        ov_next    = v_reg[STAGES-1];
        degen_next = dg_reg[STAGES-1];
        if (dg_reg[STAGES-1])
        begin
            ratio_next = '0;
        end
        else if (sat_reg[STAGES-1])
        begin
            ratio_next = RATIO_W'(1) << RATIO_FRAC_BITS;
        end
        else
        begin
            ratio_next = {1'b0, q_reg[STAGES-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= v_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                r_reg[k] <= r_next[k];
                d_reg[k] <= d_next[k];
                q_reg[k] <= q_next[k];
            end
            sat_reg   <= sat_next;
            dg_reg    <= dg_next;
            ratio_reg <= ratio_next;
            degen_reg <= degen_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_ratio = ratio_reg;
    assign out_degen = degen_reg;

endmodule

/* rtl/box_pair_iou_unit.sv */
// Intersection over union of two axis-aligned boxes in corner form, signed Q12.4
// coordinates. One box pair is taken every cycle unless the output stalls; each result
// passes four geometry stages (extents, area multipliers, union sum, flag check),
// then one stage per quotient bit of the 16-bit restoring divider, then the output
// register. The ratio is Q1.16 truncated, 65536 meaning 1.0 and also the value
// given when the intersection is not smaller than the union. When the union area
// plus epsilon is not positive the ratio is 0 and tuser is set. The whole pipeline
// holds while a result waits on m_axis_tready, so input ready falls with it. The
// epsilon port is always ready; write it only while no request is in flight.
module box_pair_iou_unit
    import bpiou_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // overlap_ratio, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // degenerate_union
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [EPS_W-1:0]      cfg_data
);

    logic [EPS_W-1:0]   epsilon_reg, epsilon_next;
    logic               en;
    logic               geom_valid;
    div_req_t           geom_req;
    logic [RATIO_W-1:0] ratio;
    logic               degen;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign epsilon_next  = cfg_valid ? cfg_data : epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPS_RESET;
        end
        else
        begin
            epsilon_reg <= epsilon_next;
        end
    end

    bpiou_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_box    (box_pair_t'(s_axis_tdata[8*COORD_BITS-1:0])),
        .epsilon   (epsilon_reg),
        .out_valid (geom_valid),
        .out_req   (geom_req)
    );

    bpiou_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geom_valid),
        .in_req    (geom_req),
        .out_valid (m_axis_tvalid),
        .out_ratio (ratio),
        .out_degen (degen)
    );

    assign m_axis_tdata = OUT_DATA_W'(ratio);
    assign m_axis_tuser = degen;

endmodule
